[rtl/tcl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command line decoder package
// Word types of the two channels, the entry carried by the byte queue and the
// request codes shared by the decoder modules.
// ----------------------------------------------------------------------------
package tcl_pkg;

    // One byte of the command line.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_byte;
    } char_word_t;

    // One decoded request.
    typedef struct packed {
        logic [3:0]         request_type;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] player_num;
        logic [30:0]        time_unit;
    } request_word_t;

    // Character classes found by the front end.
    typedef enum logic [2:0] {
        KIND_SPACE = 3'd0,
        KIND_DIGIT = 3'd1,
        KIND_MINUS = 3'd2,
        KIND_HASH  = 3'd3,
        KIND_OTHER = 3'd4
    } char_kind_t;

    // Entry of the queue between the front end and the parser.
    typedef struct packed {
        logic       has_char;   // clear for a CR or LF on the final byte
        logic       pre_bad;    // a held CR or LF counts as a stray character
        char_kind_t kind;
        logic [7:0] chr;
        logic       last;
    } queue_word_t;

    localparam logic [3:0] REQ_MSZ       = 4'd0;
    localparam logic [3:0] REQ_MCT       = 4'd1;
    localparam logic [3:0] REQ_TNA       = 4'd2;
    localparam logic [3:0] REQ_SGT       = 4'd3;
    localparam logic [3:0] REQ_BCT       = 4'd4;
    localparam logic [3:0] REQ_PPO       = 4'd5;
    localparam logic [3:0] REQ_PLV       = 4'd6;
    localparam logic [3:0] REQ_PIN       = 4'd7;
    localparam logic [3:0] REQ_SST       = 4'd8;
    localparam logic [3:0] REQ_BAD_PARAM = 4'd9;
    localparam logic [3:0] REQ_UNKNOWN   = 4'd10;

endpackage
`default_nettype wire

[rtl/tcl_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one word of the given type per handshake.
// ----------------------------------------------------------------------------
interface tcl_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/tcl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte queue
// Small register FIFO between the classifying front end and the parser.
// ----------------------------------------------------------------------------
module tcl_queue #(
    parameter int DEPTH = 4
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  tcl_pkg::queue_word_t  push_word,
    output logic                  full,
    input  wire                   pop,
    output tcl_pkg::queue_word_t  pop_word,
    output logic                  not_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tcl_pkg::queue_word_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_word  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

[rtl/tcl_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command line front end
// Accepts bytes, drops CR and LF that end the line, folds a CR or LF inside
// the line into the next entry, and classifies each character.
// ----------------------------------------------------------------------------
module tcl_front (
    input  wire                   clk,
    input  wire                   rst_n,
    tcl_stream_if.sink            char_stream,
    output logic                  push,
    output tcl_pkg::queue_word_t  push_word,
    input  wire                   full
);
    logic       pending_reg, pending_next;
    logic       accept;
    logic       eol;
    logic [7:0] c;

    assign c                 = char_stream.payload.char_code;
    assign char_stream.ready = !full;
    assign accept            = char_stream.valid && !full;
    assign eol               = (c == 8'h0D) || (c == 8'h0A);

    // A line end byte only needs a queue entry when it closes the line.
    assign push = accept && (!eol || char_stream.payload.last_byte);

    always_comb
    begin
        push_word.has_char = !eol;
        push_word.pre_bad  = pending_reg && !eol;
        push_word.chr      = c;
        push_word.last     = char_stream.payload.last_byte;
        if (c == " ")
        begin
            push_word.kind = tcl_pkg::KIND_SPACE;
        end
        else if (c >= "0" && c <= "9")
        begin
            push_word.kind = tcl_pkg::KIND_DIGIT;
        end
        else if (c == "-")
        begin
            push_word.kind = tcl_pkg::KIND_MINUS;
        end
        else if (c == "#")
        begin
            push_word.kind = tcl_pkg::KIND_HASH;
        end
        else
        begin
            push_word.kind = tcl_pkg::KIND_OTHER;
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (accept)
        begin
            pending_next = eol && !char_stream.payload.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

endmodule
`default_nettype wire

[rtl/tcl_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command line parser
// Tracks tokens, matches the verb, accumulates decimal arguments and builds
// the request on the final byte into an output register.
// ----------------------------------------------------------------------------
module tcl_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_valid,
    input  tcl_pkg::queue_word_t  q_word,
    output logic                  q_pop,
    tcl_stream_if.source          request
);
    localparam int         NUM_VERBS = 9;
    localparam logic [3:0] NO_VERB   = 4'd15;
    // Verb spellings, index 0 in the low word.
    localparam logic [NUM_VERBS-1:0][23:0] VERB_WORDS =
        {"sst", "pin", "plv", "ppo", "bct", "sgt", "tna", "mct", "msz"};

    typedef struct packed {
        logic [1:0]           token_index;
        logic                 in_token;
        logic [NUM_VERBS-1:0] vmask;      // verbs still matching the first token
        logic [2:0]           vcount;
        logic [31:0]          mag;
        logic                 neg;
        logic                 digit_seen;
        logic                 invalid;
        logic [31:0]          first_val;
        logic                 first_ok;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        token_index: 2'd0, in_token: 1'b0, vmask: '1, vcount: 3'd0,
        mag: 32'd0, neg: 1'b0, digit_seen: 1'b0, invalid: 1'b0,
        first_val: 32'd0, first_ok: 1'b0};

    function automatic logic [7:0] verb_char(input logic [23:0] w, input logic [1:0] p);
        logic [7:0] r;
        case (p)
            2'd0:    r = w[23:16];
            2'd1:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    function automatic logic [3:0] verb_code(input logic [NUM_VERBS-1:0] m);
        logic [3:0] r;
        r = NO_VERB;
        for (int j = NUM_VERBS - 1; j >= 0; j--)
        begin
            if (m[j])
            begin
                r = 4'(j);
            end
        end
        return r;
    endfunction

    function automatic logic arg_ok(input parse_state_t s);
        return s.digit_seen && !s.invalid && (s.neg || !s.mag[31]);
    endfunction

    function automatic logic [31:0] arg_value(input parse_state_t s);
        return s.neg ? (32'd0 - s.mag) : s.mag;
    endfunction

    function automatic parse_state_t end_token(input parse_state_t s);
        parse_state_t r;
        r = s;
        if (s.token_index == 2'd1)
        begin
            r.first_ok  = arg_ok(s);
            r.first_val = arg_value(s);
        end
        if (s.token_index != 2'd3)
        begin
            r.token_index = s.token_index + 2'd1;
        end
        r.in_token = 1'b0;
        return r;
    endfunction

    function automatic parse_state_t feed(input parse_state_t s, input tcl_pkg::char_kind_t kind,
                                          input logic [7:0] chr, input logic bad);
        parse_state_t r;
        logic         first;
        logic         hash_ok;
        logic [35:0]  sum;
        r       = s;
        first   = !s.in_token;
        // '#' is allowed only when the verb so far leads to ppo, plv or pin.
        hash_ok = (s.token_index == 2'd1) && (s.vmask[4:0] == '0) && (|s.vmask[7:5]);
        sum     = 36'({s.mag, 3'b000}) + 36'({s.mag, 1'b0}) + 36'(chr[3:0]);
        if (!bad && kind == tcl_pkg::KIND_SPACE)
        begin
            if (s.in_token)
            begin
                r = end_token(s);
            end
        end
        else
        begin
            if (first)
            begin
                r.in_token = 1'b1;
                if (s.token_index == 2'd1 || s.token_index == 2'd2)
                begin
                    r.mag        = '0;
                    r.neg        = 1'b0;
                    r.digit_seen = 1'b0;
                    r.invalid    = 1'b0;
                    sum          = 36'(chr[3:0]);
                end
            end
            if (s.token_index == 2'd0)
            begin
                if (!bad && s.vcount < 3'd3 && (s.vcount == 3'd0 || |s.vmask))
                begin
                    for (int j = 0; j < NUM_VERBS; j++)
                    begin
                        r.vmask[j] = (s.vcount == 3'd0 || s.vmask[j]) &&
                                     (verb_char(VERB_WORDS[j], s.vcount[1:0]) == chr);
                    end
                end
                else
                begin
                    r.vmask = '0;
                end
                if (s.vcount != 3'd4)
                begin
                    r.vcount = s.vcount + 3'd1;
                end
            end
            else if (s.token_index != 2'd3)
            begin
                if (bad)
                begin
                    r.invalid = 1'b1;
                end
                else
                begin
                    case (kind)
                        tcl_pkg::KIND_DIGIT:
                        begin
                            r.digit_seen = 1'b1;
                            if (!r.invalid)
                            begin
                                if (sum > 36'h080000000)
                                begin
                                    r.invalid = 1'b1;
                                end
                                else
                                begin
                                    r.mag = sum[31:0];
                                end
                            end
                        end
                        tcl_pkg::KIND_MINUS:
                        begin
                            if (!r.digit_seen && !r.neg)
                            begin
                                r.neg = 1'b1;
                            end
                            else
                            begin
                                r.invalid = 1'b1;
                            end
                        end
                        tcl_pkg::KIND_HASH:
                        begin
                            if (!(first && hash_ok))
                            begin
                                r.invalid = 1'b1;
                            end
                        end
                        default:
                        begin
                            r.invalid = 1'b1;
                        end
                    endcase
                end
            end
        end
        return r;
    endfunction

    function automatic tcl_pkg::request_word_t make_request(input parse_state_t s);
        tcl_pkg::request_word_t w;
        logic [3:0]             code;
        logic                   both;
        logic                   one;
        w    = '0;
        code = (s.vcount == 3'd3) ? verb_code(s.vmask) : NO_VERB;
        both = (s.token_index == 2'd3);
        one  = (s.token_index >= 2'd2);
        unique case (code) inside
            tcl_pkg::REQ_MSZ, tcl_pkg::REQ_MCT, tcl_pkg::REQ_TNA, tcl_pkg::REQ_SGT:
            begin
                w.request_type = code;
            end
            tcl_pkg::REQ_BCT:
            begin
                if (both && s.first_ok && arg_ok(s))
                begin
                    w.request_type = tcl_pkg::REQ_BCT;
                    w.coord_x      = s.first_val;
                    w.coord_y      = arg_value(s);
                end
                else
                begin
                    w.request_type = tcl_pkg::REQ_BAD_PARAM;
                    if (both && s.first_ok)
                    begin
                        w.coord_x = s.first_val;
                    end
                end
            end
            tcl_pkg::REQ_PPO, tcl_pkg::REQ_PLV, tcl_pkg::REQ_PIN:
            begin
                if (one && s.first_ok)
                begin
                    w.request_type = code;
                    w.player_num   = s.first_val;
                end
                else
                begin
                    w.request_type = tcl_pkg::REQ_BAD_PARAM;
                end
            end
            tcl_pkg::REQ_SST:
            begin
                if (one && s.first_ok && s.first_val != '0 && !s.first_val[31])
                begin
                    w.request_type = tcl_pkg::REQ_SST;
                    w.time_unit    = s.first_val[30:0];
                end
                else
                begin
                    w.request_type = tcl_pkg::REQ_BAD_PARAM;
                end
            end
            default:
            begin
                w.request_type = tcl_pkg::REQ_UNKNOWN;
            end
        endcase
        return w;
    endfunction

    parse_state_t           state_reg, state_next;
    parse_state_t           after_bad, after_char, closed;
    logic                   out_valid_reg, out_valid_next;
    tcl_pkg::request_word_t out_word_reg, out_word_next;

    assign request.valid   = out_valid_reg;
    assign request.payload = out_word_reg;

    // The final word of a line waits only while the output register holds a request that the sink is not taking.
    assign q_pop = q_valid && (!q_word.last || !out_valid_reg || request.ready);

    always_comb
    begin
        after_bad  = q_word.pre_bad ?
                     feed(state_reg, tcl_pkg::KIND_OTHER, 8'h00, 1'b1) : state_reg;
        after_char = q_word.has_char ?
                     feed(after_bad, q_word.kind, q_word.chr, 1'b0) : after_bad;
        closed     = after_char.in_token ? end_token(after_char) : after_char;

        state_next     = state_reg;
        out_valid_next = out_valid_reg && !request.ready;
        out_word_next  = out_word_reg;
        if (q_pop)
        begin
            if (q_word.last)
            begin
                state_next     = PARSE_RESET;
                out_valid_next = 1'b1;
                out_word_next  = make_request(closed);
            end
            else
            begin
                state_next = after_char;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PARSE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

endmodule
`default_nettype wire

[rtl/text_command_line_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text command line decoder
// Decodes an ASCII command line, one byte per word, into one request with
// its verb and signed decimal arguments when the final byte arrives.
//
//   Channel      Role    Word             Handshake
//   char_stream  sink    char_word_t      valid/ready, one byte per word
//   request      source  request_word_t   valid/ready, one per line
//
// One byte is taken every cycle while the queue is not full; the parser
// retires one queue entry a cycle unless a line's final entry waits. The
// final byte passes the byte queue and then the parser's output register.
// Reset clears the queue, the parse state and the output valid flag.
// A stalled request holds back only the final byte of the next line; the
// queue of QUEUE_DEPTH entries keeps bytes flowing meanwhile.
// ----------------------------------------------------------------------------
module text_command_line_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire           clk,
    input  wire           rst_n,
    tcl_stream_if.sink    char_stream,
    tcl_stream_if.source  request
);
    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 not_empty;
    tcl_pkg::queue_word_t push_word;
    tcl_pkg::queue_word_t pop_word;

    tcl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_stream),
        .push        (push),
        .push_word   (push_word),
        .full        (full)
    );

    tcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop       (pop),
        .pop_word  (pop_word),
        .not_empty (not_empty)
    );

    tcl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (not_empty),
        .q_word  (pop_word),
        .q_pop   (pop),
        .request (request)
    );

endmodule
`default_nettype wire

[rtl/tcl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command line decoder checker
// Port-level checks on the request channel of the decoder.
// ----------------------------------------------------------------------------
module tcl_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                out_valid,
    input wire                out_ready,
    input wire [3:0]          request_type,
    input wire signed [31:0]  coord_y,
    input wire signed [31:0]  player_num,
    input wire [30:0]         time_unit
);
    // A request waits until the sink takes it.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("request dropped before it was taken");

    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> request_type <= tcl_pkg::REQ_UNKNOWN)
        else $error("request code out of range");

    // The y coordinate is only reported for a good bct request.
    a_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_type != tcl_pkg::REQ_BCT |-> coord_y == '0)
        else $error("coord_y set on a request without coordinates");

    a_player_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !(request_type == tcl_pkg::REQ_PPO || request_type == tcl_pkg::REQ_PLV ||
                       request_type == tcl_pkg::REQ_PIN) |-> player_num == '0)
        else $error("player_num set on a request without a player");

    a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_type != tcl_pkg::REQ_SST |-> time_unit == '0)
        else $error("time_unit set on a request without a time");

endmodule

bind text_command_line_decoder tcl_checker u_tcl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (request.valid),
    .out_ready    (request.ready),
    .request_type (request.payload.request_type),
    .coord_y      (request.payload.coord_y),
    .player_num   (request.payload.player_num),
    .time_unit    (request.payload.time_unit)
);
`default_nettype wire
